FILE: hw/rtl/hot_pkg.sv
// Shared constants, codes and field widths of the histogram and Otsu threshold block.
`default_nettype none
package hot_pkg;

  // Default sizes of the histogram store.
  localparam int BIN_COUNT_DEF   = 256;
  localparam int COUNT_WIDTH_DEF = 32;

  // Limb width of the shared wide multiplier.
  localparam int LIMB_W = 32;

  // Field widths of the ports.
  localparam int FUNC_W     = 2;
  localparam int PIX_W      = 8;
  localparam int CHAN_W     = 3;
  localparam int BIN_OUT_W  = 8;
  localparam int TOTAL_W    = 32;
  localparam int OTSU_W     = 9;
  localparam int PEAK_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Sample value width: an 8-bit value in Q16.
  localparam int SAMPLE_W = PIX_W + 16;

  // Function codes of an input beat; the unused code behaves as evaluate.
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FN_ACC   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_EVAL  = 2'd2;
  localparam logic [FUNC_W-1:0] FN_RSVD  = 2'd3;

  // Channel codes; codes above alpha select luma.
  localparam logic [CHAN_W-1:0] CH_RED   = 3'd0;
  localparam logic [CHAN_W-1:0] CH_GREEN = 3'd1;
  localparam logic [CHAN_W-1:0] CH_BLUE  = 3'd2;
  localparam logic [CHAN_W-1:0] CH_ALPHA = 3'd3;
  localparam logic [CHAN_W-1:0] CH_LUMA  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HI = 2'd2;

  // Q16 luma weights, summing to one.
  localparam logic [15:0] LUMA_R = 16'd19595;
  localparam logic [15:0] LUMA_G = 16'd38470;
  localparam logic [15:0] LUMA_B = 16'd7471;

endpackage
`default_nettype wire

FILE: hw/rtl/hot_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module hot_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/hot_mul.sv
// Multi-cycle wide multiplier built from one 32 by 32 bit product per cycle.
`default_nettype none
module hot_mul #(
  parameter int OP_W = 176
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  input  wire logic [OP_W-1:0]                        x,
  input  wire logic [OP_W-1:0]                        y,
  output logic                                        done,
  output logic [2*((OP_W+hot_pkg::LIMB_W-1)/hot_pkg::LIMB_W)*hot_pkg::LIMB_W-1:0] prod
);
  import hot_pkg::*;

  localparam int OL  = (OP_W + LIMB_W - 1) / LIMB_W;
  localparam int PL  = 2 * OL;
  localparam int XW  = OL * LIMB_W;
  localparam int IW  = (OL > 1) ? $clog2(OL) : 1;
  localparam int AIW = $clog2(PL);

  logic [XW-1:0]     xp;
  logic [XW-1:0]     yp;
  logic [LIMB_W-1:0] xl_r [OL];
  logic [LIMB_W-1:0] yl_r [OL];
  logic [LIMB_W-1:0] acc_r [PL];
  logic [LIMB_W-1:0] carry_r;
  logic [IW-1:0]     i_r;
  logic [IW-1:0]     j_r;
  logic              busy_r;
  logic              done_r;
  logic [AIW-1:0]    k;
  logic [AIW-1:0]    k1;
  logic [2*LIMB_W-1:0] t;
  logic              row_end;

  assign xp = XW'(x);
  assign yp = XW'(y);

  // One limb product plus the running column and carry.
  assign k       = AIW'(i_r) + AIW'(j_r);
  assign k1      = k + AIW'(1);
  assign t       = (2*LIMB_W)'(xl_r[i_r]) * (2*LIMB_W)'(yl_r[j_r])
                 + (2*LIMB_W)'(acc_r[k]) + (2*LIMB_W)'(carry_r);
  assign row_end = (i_r == IW'(OL - 1));

  // Busy and done flags of the limb-product sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && row_end && (j_r == IW'(OL - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Operand limbs and the product accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      for (int n = 0; n < OL; n++) begin
        xl_r[n] <= xp[n*LIMB_W +: LIMB_W];
        yl_r[n] <= yp[n*LIMB_W +: LIMB_W];
      end
      for (int n = 0; n < PL; n++) begin
        acc_r[n] <= '0;
      end
      i_r     <= '0;
      j_r     <= '0;
      carry_r <= '0;
    end else if (busy_r) begin
      acc_r[k] <= t[LIMB_W-1:0];
      if (row_end) begin
        acc_r[k1] <= t[2*LIMB_W-1:LIMB_W];
        carry_r   <= '0;
        i_r       <= '0;
        j_r       <= j_r + IW'(1);
      end else begin
        carry_r <= t[2*LIMB_W-1:LIMB_W];
        i_r     <= i_r + IW'(1);
      end
    end
  end

  assign done = done_r;

  for (genvar g = 0; g < PL; g++) begin : g_prod
    assign prod[g*LIMB_W +: LIMB_W] = acc_r[g];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/histogram_otsu_threshold_core.sv
// Top level of the histogram engine with peak search and exact Otsu threshold.
// Reset: a clearing pass zeroes the bin memory; input is held off meanwhile.
// Accumulate: range mapping, a bit-serial divide unless clamped, then bin read-modify-write.
// Clear: a sweep writes zero to every bin.
// Evaluate: a pass over all bins, then, for each bin from the first occupied one until the
// lower class holds every pixel, up to six passes of the wide multiplier.
// One item is in flight at a time; a result waits in the output register until taken.
`default_nettype none
module histogram_otsu_threshold_core #(
  parameter int BIN_COUNT   = hot_pkg::BIN_COUNT_DEF,
  parameter int COUNT_WIDTH = hot_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [hot_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [hot_pkg::PIX_W-1:0]       in_red,
  input  wire logic [hot_pkg::PIX_W-1:0]       in_green,
  input  wire logic [hot_pkg::PIX_W-1:0]       in_blue,
  input  wire logic [hot_pkg::PIX_W-1:0]       in_alpha,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [hot_pkg::BIN_OUT_W-1:0]        out_bin_index,
  output logic [hot_pkg::TOTAL_W-1:0]          out_pixel_total,
  output logic [hot_pkg::OTSU_W-1:0]           out_otsu_twice,
  output logic [hot_pkg::PEAK_W-1:0]           out_peak_bin,
  output logic                                 out_is_empty,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [hot_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [hot_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hot_pkg::*;

  localparam int BW    = $clog2(BIN_COUNT);
  localparam int IDXW  = BW + 1;
  localparam int CW    = COUNT_WIDTH;
  localparam int NW    = CW + BW;
  localparam int SW    = NW + BW;
  localparam int AW    = NW + SW;
  localparam int NUMW  = 2 * AW;
  localparam int DENW  = 2 * NW;
  localparam int LW    = NUMW + DENW;
  localparam int OPW   = NUMW;
  localparam int PW    = 2 * ((OPW + LIMB_W - 1) / LIMB_W) * LIMB_W;
  localparam int DVW   = SAMPLE_W + BW + 2;
  localparam int KW    = $clog2(BW + 1);
  localparam int EMPTY_OTSU = 2 * (BIN_COUNT / 2);
  localparam logic [CW-1:0] CNT_MAX = '1;

  // State codes.
  localparam logic [4:0] ST_INIT    = 5'd0;
  localparam logic [4:0] ST_IDLE    = 5'd1;
  localparam logic [4:0] ST_CLR     = 5'd2;
  localparam logic [4:0] ST_MAP     = 5'd3;
  localparam logic [4:0] ST_DIV     = 5'd4;
  localparam logic [4:0] ST_ACC_RD  = 5'd5;
  localparam logic [4:0] ST_ACC_WR  = 5'd6;
  localparam logic [4:0] ST_P1      = 5'd7;
  localparam logic [4:0] ST_P2_RD   = 5'd8;
  localparam logic [4:0] ST_P2_CHK  = 5'd9;
  localparam logic [4:0] ST_M_A     = 5'd10;
  localparam logic [4:0] ST_M_B     = 5'd11;
  localparam logic [4:0] ST_M_NUM   = 5'd12;
  localparam logic [4:0] ST_M_DEN   = 5'd13;
  localparam logic [4:0] ST_M_L     = 5'd14;
  localparam logic [4:0] ST_M_R     = 5'd15;
  localparam logic [4:0] ST_PUSH    = 5'd16;

  // Control registers.
  logic [4:0]        state_r, state_nxt;
  logic [IDXW-1:0]   idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0] chan_r;
  logic [PIX_W-1:0]  rlo_r, rhi_r;
  logic [CW-1:0]     pc_r, pc_nxt;
  logic              mul_busy_r, mul_busy_nxt;
  logic              have_r, have_nxt;
  logic              rv_r, rv_nxt;

  // Payload registers.
  logic [PIX_W-1:0]  red_r, green_r, blue_r, alpha_r;
  logic [DVW-1:0]    rem_r, rem_nxt, dsh_r, dsh_nxt;
  logic [BW-1:0]     q_r, q_nxt;
  logic [KW-1:0]     k_r, k_nxt;
  logic [BW-1:0]     bin_r, bin_nxt;
  logic [BW-1:0]     ridx_r, ridx_nxt;
  logic [NW-1:0]     n_r, n_nxt, wb_r, wb_nxt;
  logic [SW-1:0]     tot_r, tot_nxt, sumb_r, sumb_nxt;
  logic [CW-1:0]     best_n_r, best_n_nxt;
  logic [BW-1:0]     peak_r, peak_nxt;
  logic [AW-1:0]     a_r, a_nxt, d_r, d_nxt;
  logic [NUMW-1:0]   num_r, num_nxt, bnum_r, bnum_nxt;
  logic [DENW-1:0]   den_r, den_nxt, bden_r, bden_nxt;
  logic [LW-1:0]     l_r, l_nxt;
  logic [BW-1:0]     first_r, first_nxt, last_r, last_nxt;
  logic [BIN_OUT_W-1:0] res_bin_r, res_bin_nxt;
  logic [OTSU_W-1:0] res_otsu_r, res_otsu_nxt;
  logic [PEAK_W-1:0] res_peak_r, res_peak_nxt;
  logic [BIN_OUT_W-1:0] out_bin_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic [OTSU_W-1:0] out_otsu_r;
  logic [PEAK_W-1:0] out_peak_r;
  logic              out_empty_r;

  // Memory and multiplier connections.
  logic              ram_we;
  logic [BW-1:0]     ram_waddr, ram_raddr;
  logic [CW-1:0]     ram_wdata, ram_rdata;
  logic              mul_start, mul_done;
  logic [OPW-1:0]    mul_x, mul_y;
  logic [PW-1:0]     mul_prod;
  logic              push;

  hot_ram #(.WIDTH(CW), .DEPTH(BIN_COUNT)) u_bins (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  hot_mul #(.OP_W(OPW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .x     (mul_x),
    .y     (mul_y),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Sequencer: mapping, bin update, sweeps and the two evaluation passes.
  always_comb begin
    logic [25:0]          luma_sum;
    logic [SAMPLE_W-1:0]  v;
    logic [SAMPLE_W-1:0]  lo;
    logic [SAMPLE_W-1:0]  den_s;
    logic [DVW-1:0]       numer;
    logic [DVW:0]         trial;
    logic [CW-1:0]        c;
    logic [NW-1:0]        wb_sum;
    logic [AW-1:0]        b_val;
    logic [LW-1:0]        r_val;
    logic                 adv;
    logic                 fin;
    logic [BW:0]          fl_sum;

    state_nxt     = state_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pc_nxt        = pc_r;
    mul_busy_nxt  = mul_busy_r;
    have_nxt      = have_r;
    rv_nxt        = rv_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    k_nxt         = k_r;
    bin_nxt       = bin_r;
    ridx_nxt      = ridx_r;
    n_nxt         = n_r;
    wb_nxt        = wb_r;
    tot_nxt       = tot_r;
    sumb_nxt      = sumb_r;
    best_n_nxt    = best_n_r;
    peak_nxt      = peak_r;
    a_nxt         = a_r;
    d_nxt         = d_r;
    num_nxt       = num_r;
    bnum_nxt      = bnum_r;
    den_nxt       = den_r;
    bden_nxt      = bden_r;
    l_nxt         = l_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    res_bin_nxt   = res_bin_r;
    res_otsu_nxt  = res_otsu_r;
    res_peak_nxt  = res_peak_r;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[BW-1:0];
    ram_wdata     = '0;
    ram_raddr     = idx_r[BW-1:0];
    mul_start     = 1'b0;
    mul_x         = '0;
    mul_y         = '0;
    push          = 1'b0;
    adv           = 1'b0;
    fin           = 1'b0;
    c             = ram_rdata;
    wb_sum        = wb_r + NW'(c);
    b_val         = mul_prod[AW-1:0];
    r_val         = mul_prod[LW-1:0];

    // Sample selection and range mapping terms.
    luma_sum = 26'(red_r) * 26'(LUMA_R) + 26'(green_r) * 26'(LUMA_G)
             + 26'(blue_r) * 26'(LUMA_B);
    case (chan_r)
      CH_RED:   v = {red_r, 16'd0};
      CH_GREEN: v = {green_r, 16'd0};
      CH_BLUE:  v = {blue_r, 16'd0};
      CH_ALPHA: v = {alpha_r, 16'd0};
      default:  v = SAMPLE_W'(luma_sum);
    endcase
    lo    = {rlo_r, 16'd0};
    den_s = {rhi_r - rlo_r, 16'd0};
    numer = DVW'(v - lo) * DVW'(BIN_COUNT - 1);
    trial = {1'b0, rem_r} - {1'b0, dsh_r};

    // Operands of the shared multiplier.
    case (state_r)
      ST_M_A: begin
        mul_x = OPW'(n_r);
        mul_y = OPW'(sumb_r);
      end
      ST_M_B: begin
        mul_x = OPW'(wb_r);
        mul_y = OPW'(tot_r);
      end
      ST_M_NUM: begin
        mul_x = OPW'(d_r);
        mul_y = OPW'(d_r);
      end
      ST_M_DEN: begin
        mul_x = OPW'(wb_r);
        mul_y = OPW'(n_r - wb_r);
      end
      ST_M_L: begin
        mul_x = OPW'(num_r);
        mul_y = OPW'(bden_r);
      end
      ST_M_R: begin
        mul_x = OPW'(bnum_r);
        mul_y = OPW'(den_r);
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
    if ((state_r >= ST_M_A) && (state_r <= ST_M_R)) begin
      if (!mul_busy_r) begin
        mul_start    = 1'b1;
        mul_busy_nxt = 1'b1;
      end else if (mul_done) begin
        mul_busy_nxt = 1'b0;
      end
    end

    case (state_r)
      ST_INIT, ST_CLR: begin
        ram_we = 1'b1;
        if (idx_r == IDXW'(BIN_COUNT - 1)) begin
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_PUSH;
        end else begin
          idx_nxt = idx_r + IDXW'(1);
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          res_bin_nxt  = '0;
          res_otsu_nxt = '0;
          res_peak_nxt = '0;
          case (in_func)
            FN_CLEAR: begin
              pc_nxt    = '0;
              idx_nxt   = '0;
              state_nxt = ST_CLR;
            end
            FN_ACC: begin
              state_nxt = ST_MAP;
            end
            default: begin
              if (pc_r == '0) begin
                res_otsu_nxt = OTSU_W'(EMPTY_OTSU);
                state_nxt    = ST_PUSH;
              end else begin
                n_nxt      = '0;
                tot_nxt    = '0;
                best_n_nxt = '0;
                peak_nxt   = '0;
                idx_nxt    = '0;
                rv_nxt     = 1'b0;
                state_nxt  = ST_P1;
              end
            end
          endcase
        end
      end

      // Clamp the ends of the range, otherwise divide with rounding.
      ST_MAP: begin
        if (v <= lo) begin
          bin_nxt   = '0;
          state_nxt = ST_ACC_RD;
        end else if ((rhi_r <= rlo_r) || (v >= {rhi_r, 16'd0})) begin
          bin_nxt   = BW'(BIN_COUNT - 1);
          state_nxt = ST_ACC_RD;
        end else begin
          rem_nxt   = (numer << 1) + DVW'(den_s);
          dsh_nxt   = (DVW'(den_s) << 1) << (BW - 1);
          q_nxt     = '0;
          k_nxt     = KW'(BW - 1);
          state_nxt = ST_DIV;
        end
      end

      // Restoring division, one quotient bit a cycle.
      ST_DIV: begin
        if (!trial[DVW]) begin
          rem_nxt = trial[DVW-1:0];
          q_nxt   = BW'({q_r, 1'b1});
        end else begin
          q_nxt   = BW'({q_r, 1'b0});
        end
        dsh_nxt = dsh_r >> 1;
        if (k_r == '0) begin
          bin_nxt   = q_nxt;
          state_nxt = ST_ACC_RD;
        end else begin
          k_nxt = k_r - KW'(1);
        end
      end

      ST_ACC_RD: begin
        ram_raddr = bin_r;
        state_nxt = ST_ACC_WR;
      end

      // Saturating increment of the bin and of the pixel count.
      ST_ACC_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = bin_r;
        ram_wdata   = (c == CNT_MAX) ? c : c + CW'(1);
        pc_nxt      = (pc_r == CNT_MAX) ? pc_r : pc_r + CW'(1);
        res_bin_nxt = BIN_OUT_W'(bin_r);
        state_nxt   = ST_PUSH;
      end

      // First pass: bin total, weighted total and peak.
      ST_P1: begin
        rv_nxt   = (idx_r != IDXW'(BIN_COUNT));
        ridx_nxt = idx_r[BW-1:0];
        if (rv_r) begin
          n_nxt   = n_r + NW'(c);
          tot_nxt = tot_r + SW'(ridx_r) * SW'(c);
          if (c > best_n_r) begin
            best_n_nxt = c;
            peak_nxt   = ridx_r;
          end
        end
        if (idx_r != IDXW'(BIN_COUNT)) begin
          idx_nxt = idx_r + IDXW'(1);
        end else if (!rv_r) begin
          idx_nxt   = '0;
          wb_nxt    = '0;
          sumb_nxt  = '0;
          have_nxt  = 1'b0;
          first_nxt = BW'(BIN_COUNT / 2);
          last_nxt  = BW'(BIN_COUNT / 2);
          state_nxt = ST_P2_RD;
        end
      end

      ST_P2_RD: begin
        state_nxt = ST_P2_CHK;
      end

      // Second pass: grow the lower class by one bin.
      ST_P2_CHK: begin
        wb_nxt = wb_sum;
        if (wb_sum == '0) begin
          adv = 1'b1;
        end else if (wb_sum >= n_r) begin
          fin = 1'b1;
        end else begin
          sumb_nxt  = sumb_r + SW'(idx_r[BW-1:0]) * SW'(c);
          state_nxt = ST_M_A;
        end
      end

      ST_M_A: begin
        if (mul_busy_r && mul_done) begin
          a_nxt     = mul_prod[AW-1:0];
          state_nxt = ST_M_B;
        end
      end

      ST_M_B: begin
        if (mul_busy_r && mul_done) begin
          d_nxt     = (a_r >= b_val) ? a_r - b_val : b_val - a_r;
          state_nxt = ST_M_NUM;
        end
      end

      ST_M_NUM: begin
        if (mul_busy_r && mul_done) begin
          num_nxt   = mul_prod[NUMW-1:0];
          state_nxt = ST_M_DEN;
        end
      end

      ST_M_DEN: begin
        if (mul_busy_r && mul_done) begin
          den_nxt = mul_prod[DENW-1:0];
          if (!have_r) begin
            have_nxt  = 1'b1;
            bnum_nxt  = num_r;
            bden_nxt  = mul_prod[DENW-1:0];
            first_nxt = idx_r[BW-1:0];
            last_nxt  = idx_r[BW-1:0];
            adv       = 1'b1;
          end else begin
            state_nxt = ST_M_L;
          end
        end
      end

      ST_M_L: begin
        if (mul_busy_r && mul_done) begin
          l_nxt     = mul_prod[LW-1:0];
          state_nxt = ST_M_R;
        end
      end

      // Exact comparison of the two variance fractions.
      ST_M_R: begin
        if (mul_busy_r && mul_done) begin
          if (l_r > r_val) begin
            bnum_nxt  = num_r;
            bden_nxt  = den_r;
            first_nxt = idx_r[BW-1:0];
            last_nxt  = idx_r[BW-1:0];
          end else if (l_r == r_val) begin
            last_nxt = idx_r[BW-1:0];
          end
          adv = 1'b1;
        end
      end

      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          push          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Step to the next bin or close the evaluation.
    if (adv && (idx_r != IDXW'(BIN_COUNT - 1))) begin
      idx_nxt   = idx_r + IDXW'(1);
      state_nxt = ST_P2_RD;
      fl_sum    = '0;
    end else if (adv || fin) begin
      fl_sum       = {1'b0, first_nxt} + {1'b0, last_nxt};
      res_otsu_nxt = OTSU_W'(fl_sum);
      res_peak_nxt = PEAK_W'(peak_r);
      state_nxt    = ST_PUSH;
    end else begin
      fl_sum = '0;
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      chan_r      <= CH_LUMA;
      rlo_r       <= '0;
      rhi_r       <= '1;
      pc_r        <= '0;
      mul_busy_r  <= 1'b0;
      have_r      <= 1'b0;
      rv_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      mul_busy_r  <= mul_busy_nxt;
      have_r      <= have_nxt;
      rv_r        <= rv_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          REG_CHANNEL:  chan_r <= cfg_data[CHAN_W-1:0];
          REG_RANGE_LO: rlo_r  <= cfg_data;
          REG_RANGE_HI: rhi_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      red_r   <= in_red;
      green_r <= in_green;
      blue_r  <= in_blue;
      alpha_r <= in_alpha;
    end
    rem_r      <= rem_nxt;
    dsh_r      <= dsh_nxt;
    q_r        <= q_nxt;
    k_r        <= k_nxt;
    bin_r      <= bin_nxt;
    ridx_r     <= ridx_nxt;
    n_r        <= n_nxt;
    wb_r       <= wb_nxt;
    tot_r      <= tot_nxt;
    sumb_r     <= sumb_nxt;
    best_n_r   <= best_n_nxt;
    peak_r     <= peak_nxt;
    a_r        <= a_nxt;
    d_r        <= d_nxt;
    num_r      <= num_nxt;
    bnum_r     <= bnum_nxt;
    den_r      <= den_nxt;
    bden_r     <= bden_nxt;
    l_r        <= l_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    res_bin_r  <= res_bin_nxt;
    res_otsu_r <= res_otsu_nxt;
    res_peak_r <= res_peak_nxt;
    if (push) begin
      out_bin_r   <= res_bin_r;
      out_total_r <= TOTAL_W'(pc_r);
      out_otsu_r  <= res_otsu_r;
      out_peak_r  <= res_peak_r;
      out_empty_r <= (pc_r == '0);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bin_index   = out_bin_r;
  assign out_pixel_total = out_total_r;
  assign out_otsu_twice  = out_otsu_r;
  assign out_peak_bin    = out_peak_r;
  assign out_is_empty    = out_empty_r;

  // Only one item is worked on at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // The multiplier only reports completion of a product that was started.
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> mul_busy_r)
    else $error("multiplier done without a running product");

  // A result is presented only from the push state.
  a_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_PUSH))
    else $error("result presented outside the push state");

  // The plateau of maximal variance never runs backwards.
  a_plateau: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |-> (first_r <= last_r))
    else $error("plateau ends out of order");

endmodule
`default_nettype wire

FILE: verif/histogram_otsu_checker.sv
// Checker for the histogram core: predicts every result beat and compares it with the output.
module histogram_otsu_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [hot_pkg::FUNC_W-1:0]        in_func,
  input  logic [hot_pkg::PIX_W-1:0]         in_red,
  input  logic [hot_pkg::PIX_W-1:0]         in_green,
  input  logic [hot_pkg::PIX_W-1:0]         in_blue,
  input  logic [hot_pkg::PIX_W-1:0]         in_alpha,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [hot_pkg::BIN_OUT_W-1:0]     out_bin_index,
  input  logic [hot_pkg::TOTAL_W-1:0]       out_pixel_total,
  input  logic [hot_pkg::OTSU_W-1:0]        out_otsu_twice,
  input  logic [hot_pkg::PEAK_W-1:0]        out_peak_bin,
  input  logic                              out_is_empty,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [hot_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hot_pkg::CFG_DATA_W-1:0]    cfg_data,
  output int                                fail_count,
  output int                                results_pending
);
  import hot_pkg::*;

  localparam int NBINS = 256;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [BIN_OUT_W-1:0] bin_index;
    logic [TOTAL_W-1:0]   pixel_total;
    logic [OTSU_W-1:0]    otsu_twice;
    logic [PEAK_W-1:0]    peak_bin;
    logic                 is_empty;
  } stats_beat_t;

  stats_beat_t      stats_fifo[$];
  logic [31:0]      model_bins[NBINS];
  logic [31:0]      model_total;
  logic [CHAN_W-1:0] chan_sel;
  logic [7:0]       lo_sel;
  logic [7:0]       hi_sel;

  assign results_pending = stats_fifo.size();

  // Sample of the selected channel in Q16; codes beyond alpha fall back to luma.
  function automatic logic [31:0] sample_q16(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                             logic [7:0] a);
    case (chan_sel)
      CH_RED:   return {8'd0, r, 16'd0};
      CH_GREEN: return {8'd0, g, 16'd0};
      CH_BLUE:  return {8'd0, b, 16'd0};
      CH_ALPHA: return {8'd0, a, 16'd0};
      default:  return r * 32'(LUMA_R) + g * 32'(LUMA_G) + b * 32'(LUMA_B);
    endcase
  endfunction

  // Rounded and clamped mapping of a Q16 sample onto a bin.
  function automatic logic [7:0] bin_of(logic [31:0] v);
    logic [63:0] lo_q, den, num, bin;
    lo_q = 64'(lo_sel) << 16;
    if (64'(v) <= lo_q) return 8'd0;
    if (hi_sel <= lo_sel) return 8'(NBINS - 1);
    den = 64'(hi_sel - lo_sel) << 16;
    num = (64'(v) - lo_q) * (NBINS - 1);
    bin = (2 * num + den) / (2 * den);
    return (bin > NBINS - 1) ? 8'(NBINS - 1) : bin[7:0];
  endfunction

  function automatic logic [7:0] peak_of();
    logic [31:0] best_n;
    logic [7:0]  best;
    best_n = 0;
    best = 0;
    for (int i = 0; i < NBINS; i++) begin
      if (model_bins[i] > best_n) begin
        best_n = model_bins[i];
        best = 8'(i);
      end
    end
    return best;
  endfunction

  // Exact between-class variance search; returns the sum of the plateau ends.
  function automatic logic [8:0] otsu_of();
    logic [511:0] wsum, sum_low, a, b, d, num, den, best_num, best_den, l, r;
    logic [63:0]  n, wb;
    int           first, last;
    bit           have;
    n = 0;
    wsum = 0;
    sum_low = 0;
    best_num = 0;
    best_den = 1;
    first = NBINS / 2;
    last = NBINS / 2;
    have = 0;
    for (int i = 0; i < NBINS; i++) begin
      n += 64'(model_bins[i]);
      wsum += 512'(i) * 512'(model_bins[i]);
    end
    if (model_total == 0) return 9'(2 * (NBINS / 2));
    wb = 0;
    for (int i = 0; i < NBINS; i++) begin
      wb += 64'(model_bins[i]);
      if (wb == 0) continue;
      if (wb >= n) break;
      sum_low += 512'(i) * 512'(model_bins[i]);
      a = 512'(n) * sum_low;
      b = 512'(wb) * wsum;
      d = (a >= b) ? a - b : b - a;
      num = d * d;
      den = 512'(wb) * 512'(n - wb);
      l = num * best_den;
      r = best_num * den;
      if (!have || l > r) begin
        have = 1;
        best_num = num;
        best_den = den;
        first = i;
        last = i;
      end else if (l == r) begin
        last = i;
      end
    end
    return 9'(first + last);
  endfunction

  // Apply one accepted input beat to the model and queue its result.
  function automatic void predict(logic [FUNC_W-1:0] f, logic [7:0] r, logic [7:0] g,
                                  logic [7:0] b, logic [7:0] a);
    stats_beat_t e;
    e = '0;
    if (f == FN_CLEAR) begin
      foreach (model_bins[i]) model_bins[i] = 0;
      model_total = 0;
    end else if (f == FN_ACC) begin
      e.bin_index = bin_of(sample_q16(r, g, b, a));
      if (model_bins[e.bin_index] < COUNT_MAX) model_bins[e.bin_index]++;
      if (model_total < COUNT_MAX) model_total++;
    end else begin
      e.otsu_twice = otsu_of();
      e.peak_bin = peak_of();
    end
    e.pixel_total = model_total;
    e.is_empty = (model_total == 0);
    stats_fifo.push_back(e);
  endfunction

  // Watch the three channels; handshake values are those before the edge.
  always @(posedge clk) begin
    stats_beat_t e, got;
    if (!rst_n) begin
      foreach (model_bins[i]) model_bins[i] = 0;
      model_total = 0;
      chan_sel = CH_LUMA;
      lo_sel = 8'd0;
      hi_sel = 8'd255;
      stats_fifo.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CHANNEL:  chan_sel = cfg_data[CHAN_W-1:0];
          REG_RANGE_LO: lo_sel = cfg_data;
          REG_RANGE_HI: hi_sel = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = '{out_bin_index, out_pixel_total, out_otsu_twice, out_peak_bin, out_is_empty};
        if (stats_fifo.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("Unexpected result beat: %p", got);
        end else begin
          e = stats_fifo.pop_front();
          if (got !== e) begin
            fail_count++;
            if (fail_count <= 10)
              $display("Result mismatch: expected %p, actual %p", e, got);
          end
        end
      end
      if (in_valid && in_ready) predict(in_func, in_red, in_green, in_blue, in_alpha);
    end
  end

endmodule

FILE: verif/testbench.sv
// Top of the histogram core testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import hot_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     in_func = FN_CLEAR;
  logic [PIX_W-1:0]      in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [BIN_OUT_W-1:0]  out_bin_index;
  logic [TOTAL_W-1:0]    out_pixel_total;
  logic [OTSU_W-1:0]     out_otsu_twice;
  logic [PEAK_W-1:0]     out_peak_bin;
  logic                  out_is_empty;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_CHANNEL;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    results_pending;
  int                    burst_left = 0;
  int                    idle_cycles = 0;

  histogram_otsu_threshold_core u_dut (.*);

  histogram_otsu_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stall pattern: each clock picks always ready, a random value or a stall.
  always @(posedge clk) begin
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 50) out_ready <= 1'b1;
    else if (mode < 90) out_ready <= 1'($urandom_range(0, 1));
    else out_ready <= 1'b0;
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Send one pixel beat, with bursts of random length separated by random gaps.
  task automatic send_pixel(logic [FUNC_W-1:0] f, logic [7:0] r, logic [7:0] g,
                            logic [7:0] b, logic [7:0] a);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_func <= f;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_alpha <= a;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(logic [CHAN_W-1:0] ch, logic [7:0] lo, logic [7:0] hi);
    write_reg(REG_CHANNEL, CFG_DATA_W'(ch));
    write_reg(REG_RANGE_LO, lo);
    write_reg(REG_RANGE_HI, hi);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly pixels drawn from two clusters so the threshold search
  // sees shaped histograms, with occasional clears and evaluations.
  task automatic random_phase(int count);
    logic [7:0] c0, c1, base;
    int         pick;
    c0 = 8'($urandom_range(0, 255));
    c1 = 8'($urandom_range(0, 255));
    send_pixel(FN_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        send_pixel(FN_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 7) begin
        send_pixel((pick == 6) ? FN_RSVD : FN_EVAL, 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom));
      end else if (pick < 25) begin
        send_pixel(FN_ACC, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      end else begin
        base = (pick < 60) ? c0 : c1;
        send_pixel(FN_ACC, base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)),
                   base ^ 8'($urandom_range(0, 3)), base ^ 8'($urandom_range(0, 3)));
      end
    end
    send_pixel(FN_EVAL, 8'd0, 8'd0, 8'd0, 8'd0);
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty evaluation, reserved code, single pixel, extremes, bimodal.
    send_pixel(FN_EVAL, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(FN_CLEAR, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(FN_RSVD, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(FN_ACC, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(FN_EVAL, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(FN_ACC, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(FN_ACC, 8'hFF, 8'h00, 8'h00, 8'h55);
    send_pixel(FN_ACC, 8'h00, 8'hFF, 8'h00, 8'hAA);
    send_pixel(FN_ACC, 8'h00, 8'h00, 8'hFF, 8'h00);
    send_pixel(FN_ACC, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(FN_EVAL, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(FN_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(FN_EVAL, 8'd0, 8'd0, 8'd0, 8'd0);
    drain();

    // Settings across channels and ranges, including inverted and equal ranges.
    set_config(CH_RED, 8'd0, 8'd255);
    random_phase(50);
    set_config(CH_GREEN, 8'd0, 8'd1);
    random_phase(40);
    set_config(CH_BLUE, 8'd254, 8'd255);
    random_phase(40);
    set_config(CH_ALPHA, 8'd100, 8'd50);
    random_phase(40);
    set_config(CH_LUMA, 8'd128, 8'd128);
    random_phase(40);
    set_config(3'd5, 8'd16, 8'd235);
    random_phase(40);
    set_config(3'd7, 8'd0, 8'd255);
    random_phase(40);
    for (int p = 0; p < 5; p++) begin
      set_config(CHAN_W'($urandom_range(0, 7)), 8'($urandom), 8'($urandom));
      random_phase(40);
    end

    if (fail_count == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
